@@ rtl/core/vlf_pkg.sv @@
// shared types, constants and fixed-point helpers for the van leer face flux core
`default_nettype none
package vlf_pkg;

    // every internal quantity is a signed q.16 value held in 63 bits
    localparam int QW     = 63;
    localparam int MAG_W  = 61;
    localparam int FRAC_W = 16;
    localparam int OUT_W  = 56;
    localparam int GAM_W  = 18;
    localparam int G2_W   = 20;

    typedef logic signed [QW-1:0] q_t;

    localparam q_t QLIM    = 63'sh1FFF_FFFF_FFFF_FFFF;
    localparam q_t QONE    = 63'sd65536;
    localparam q_t OUT_MAX = 63'sh007F_FFFF_FFFF_FFFF;
    localparam q_t OUT_MIN = -63'sh0080_0000_0000_0000;

    // internal limit at the width of a raw sum
    localparam logic signed [QW:0] QLIM_W = 64'sh1FFF_FFFF_FFFF_FFFF;

    // gamma register reset and the values derived from it
    localparam longint G_RST    = 91750;
    localparam longint GM1_RST  = G_RST - 65536;
    localparam longint G2M1_RST = (G_RST * G_RST - 64'h1_0000_0000) >>> 16;

    // unit latencies and the latency of one side of the face
    localparam int MUL_LAT  = 4;
    localparam int DIV_LAT  = MAG_W + 3;
    localparam int SIDE_LAT = 6 * MUL_LAT + 2 * DIV_LAT + 8;

    // context that travels down one side pipeline
    typedef struct packed {
        q_t nx;
        q_t ny;
        q_t rho;
        q_t vx;
        q_t vy;
        q_t c;
        q_t pvx;
        q_t pvy;
        q_t pxx;
        q_t pyy;
        q_t cc;
        q_t rc;
        q_t vn;
        q_t vmags;
        q_t s2c;
        q_t m;
        q_t crho;
        q_t vnvn;
        q_t gvn;
        q_t rhovm;
        q_t a;
        q_t wnum;
        q_t hrv;
        q_t hd;
        q_t aa;
        q_t haa;
        q_t mach;
        q_t p;
        q_t w;
        q_t q2;
        q_t mp;
        q_t e2;
        q_t mvx;
        q_t pnx;
        q_t mvy;
        q_t pny;
        q_t t1;
        q_t nxw;
        q_t nyw;
        q_t f1f;
        q_t f2f;
        q_t ux;
        q_t uy;
        q_t dpg;
        q_t ef;
        q_t ef3;
        q_t t2;
        q_t f1;
        q_t f1x;
        q_t f1y;
        q_t f13;
        logic full;
        logic none;
    } ctx_t;

    function automatic q_t sat64(input logic signed [QW:0] v);
        q_t r;
        if (v > QLIM_W)
            r = QLIM;
        else if (v < -QLIM_W)
            r = -QLIM;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    function automatic q_t addq(input q_t a, input q_t b);
        return sat64({a[QW-1], a} + {b[QW-1], b});
    endfunction

    function automatic q_t subq(input q_t a, input q_t b);
        return sat64({a[QW-1], a} - {b[QW-1], b});
    endfunction

    // product with one half, rounding the magnitude toward zero
    function automatic q_t halfq(input q_t x);
        q_t r;
        if (x[QW-1])
            r = -((-x) >>> 1);
        else
            r = x >>> 1;
        return r;
    endfunction

    function automatic q_t quarterq(input q_t x);
        q_t r;
        if (x[QW-1])
            r = -((-x) >>> 2);
        else
            r = x >>> 2;
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] magq(input q_t x);
        q_t t;
        t = x[QW-1] ? -x : x;
        return t[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/vlf_dly.sv @@
// enable-gated delay line that carries a side context alongside an arithmetic unit
`default_nettype none
module vlf_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];
endmodule
`default_nettype wire

@@ rtl/core/vlf_mul.sv @@
// four-stage saturating q.16 multiplier built from partial products of 31-bit and 30-bit operand halves
`default_nettype none
module vlf_mul (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire vlf_pkg::q_t a,
    input  wire vlf_pkg::q_t b,
    output vlf_pkg::q_t      p
);
    import vlf_pkg::*;

    logic              s1_sgn_reg;
    logic [MAG_W-1:0]  s1_ma_reg;
    logic [MAG_W-1:0]  s1_mb_reg;
    logic              s2_sgn_reg;
    logic [61:0]       pp00_reg;
    logic [60:0]       pp01_reg;
    logic [60:0]       pp10_reg;
    logic [59:0]       pp11_reg;
    logic              s3_sgn_reg;
    logic [121:0]      sum_reg;
    q_t                p_reg;
    logic [MAG_W-1:0]  mag;

    // drop 16 fraction bits, clip at the internal limit
    assign mag = (|sum_reg[121:77]) ? QLIM[MAG_W-1:0] : sum_reg[76:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sgn_reg <= a[QW-1] ^ b[QW-1];
            s1_ma_reg  <= magq(a);
            s1_mb_reg  <= magq(b);
            s2_sgn_reg <= s1_sgn_reg;
            pp00_reg   <= 62'(s1_ma_reg[30:0]) * 62'(s1_mb_reg[30:0]);
            pp01_reg   <= 61'(s1_ma_reg[30:0]) * 61'(s1_mb_reg[60:31]);
            pp10_reg   <= 61'(s1_ma_reg[60:31]) * 61'(s1_mb_reg[30:0]);
            pp11_reg   <= 60'(s1_ma_reg[60:31]) * 60'(s1_mb_reg[60:31]);
            s3_sgn_reg <= s2_sgn_reg;
            sum_reg    <= 122'(pp00_reg) + (122'(pp01_reg) << 31)
                        + (122'(pp10_reg) << 31) + (122'(pp11_reg) << 62);
            p_reg      <= s3_sgn_reg ? -q_t'({2'b00, mag}) : q_t'({2'b00, mag});
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

@@ rtl/core/vlf_div.sv @@
// pipelined restoring q.16 divider, one quotient bit per stage, saturating
`default_nettype none
module vlf_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire vlf_pkg::q_t a,
    input  wire vlf_pkg::q_t b,
    output vlf_pkg::q_t      q
);
    import vlf_pkg::*;

    logic              sgn0_reg;
    logic [MAG_W-1:0]  ua0_reg;
    logic [MAG_W-1:0]  ub0_reg;

    logic [MAG_W-1:0]  ua_reg  [0:MAG_W];
    logic [MAG_W-1:0]  ub_reg  [0:MAG_W];
    logic [MAG_W-1:0]  rem_reg [0:MAG_W];
    logic [MAG_W-1:0]  quo_reg [0:MAG_W];
    logic              sgn_reg [0:MAG_W];
    logic              sat_reg [0:MAG_W];
    logic              zro_reg [0:MAG_W];

    logic [MAG_W-1:0]  rem_next [0:MAG_W-1];
    logic [MAG_W-1:0]  quo_next [0:MAG_W-1];

    q_t                q_reg;
    logic              sat0;

    // quotient would not fit below the limit, or divisor zero with nonzero dividend
    assign sat0 = ((ub0_reg != '0) || (ua0_reg != '0))
                && ({45'b0, ua0_reg} >= {ub0_reg, 45'b0});

    always_comb
    begin
        logic [MAG_W:0]          sh;
        logic [MAG_W+FRAC_W-1:0] dv;
        for (int k = 0; k < MAG_W; k++)
        begin
            dv = {ua_reg[k], {FRAC_W{1'b0}}};
            sh = {rem_reg[k], dv[MAG_W-1-k]};
            quo_next[k] = quo_reg[k];
            if (sh >= {1'b0, ub_reg[k]})
            begin
                rem_next[k] = MAG_W'(sh - {1'b0, ub_reg[k]});
                quo_next[k][MAG_W-1-k] = 1'b1;
            end
            else
            begin
                rem_next[k] = sh[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn0_reg   <= a[QW-1] ^ b[QW-1];
            ua0_reg    <= magq(a);
            ub0_reg    <= magq(b);
            ua_reg[0]  <= ua0_reg;
            ub_reg[0]  <= ub0_reg;
            rem_reg[0] <= {45'b0, ua0_reg[MAG_W-1:45]};
            quo_reg[0] <= '0;
            sgn_reg[0] <= sgn0_reg;
            sat_reg[0] <= sat0;
            zro_reg[0] <= (ub0_reg == '0) && (ua0_reg == '0);
            for (int k = 0; k < MAG_W; k++)
            begin
                ua_reg[k+1]  <= ua_reg[k];
                ub_reg[k+1]  <= ub_reg[k];
                rem_reg[k+1] <= rem_next[k];
                quo_reg[k+1] <= quo_next[k];
                sgn_reg[k+1] <= sgn_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                zro_reg[k+1] <= zro_reg[k];
            end
            if (sat_reg[MAG_W])
                q_reg <= sgn_reg[MAG_W] ? -QLIM : QLIM;
            else if (zro_reg[MAG_W])
                q_reg <= '0;
            else
                q_reg <= sgn_reg[MAG_W] ? -q_t'({2'b00, quo_reg[MAG_W]})
                                        : q_t'({2'b00, quo_reg[MAG_W]});
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

@@ rtl/core/vlf_side.sv @@
// one split half of the face flux: plus part from the left, minus part from the right
`default_nettype none
module vlf_side (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic        plus_side,
    input  wire vlf_pkg::q_t nx,
    input  wire vlf_pkg::q_t ny,
    input  wire vlf_pkg::q_t rho,
    input  wire vlf_pkg::q_t vx,
    input  wire vlf_pkg::q_t vy,
    input  wire vlf_pkg::q_t c,
    input  wire vlf_pkg::q_t g,
    input  wire vlf_pkg::q_t gm1,
    input  wire vlf_pkg::q_t g2m1,
    output vlf_pkg::q_t      f0,
    output vlf_pkg::q_t      f1,
    output vlf_pkg::q_t      f2,
    output vlf_pkg::q_t      f3
);
    import vlf_pkg::*;

    ctx_t c0;
    ctx_t m1_dly, m1_ctx, a1_reg, a1_next;
    ctx_t m2_dly, m2_ctx, a2_reg, a2_next;
    ctx_t m3_dly, m3_ctx, a3_reg, a3_next;
    ctx_t d1_dly, d1_ctx, a4_reg, a4_next;
    ctx_t m4_dly, m4_ctx, a5_reg, a5_next;
    ctx_t d2_dly, d2_ctx, a6_reg, a6_next;
    ctx_t m5_dly, m5_ctx, a7_reg, a7_next;
    ctx_t m6_dly, m6_ctx;
    q_t   f0_reg, f1_reg, f2_reg, f3_reg;

    q_t pvx, pvy, pxx, pyy, cc, rc;
    q_t mm, crho, vnvn, gvn, rhovm;
    q_t aa;
    q_t mach, pp, ww, q2;
    q_t mvx, pnx, mvy, pny, t1, nxw, nyw;
    q_t dpg;
    q_t ef3, t2;
    q_t f1x, f1y, f13;

    always_comb
    begin
        c0     = '0;
        c0.nx  = nx;
        c0.ny  = ny;
        c0.rho = rho;
        c0.vx  = vx;
        c0.vy  = vy;
        c0.c   = c;
    end

    // products of the raw state
    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m1
        (.clk(clk), .en(en), .din(c0), .dout(m1_dly));
    vlf_mul u_m1_pvx (.clk(clk), .en(en), .a(c0.vx),  .b(c0.nx), .p(pvx));
    vlf_mul u_m1_pvy (.clk(clk), .en(en), .a(c0.vy),  .b(c0.ny), .p(pvy));
    vlf_mul u_m1_pxx (.clk(clk), .en(en), .a(c0.vx),  .b(c0.vx), .p(pxx));
    vlf_mul u_m1_pyy (.clk(clk), .en(en), .a(c0.vy),  .b(c0.vy), .p(pyy));
    vlf_mul u_m1_cc  (.clk(clk), .en(en), .a(c0.c),   .b(c0.c),  .p(cc));
    vlf_mul u_m1_rc  (.clk(clk), .en(en), .a(c0.rho), .b(c0.c),  .p(rc));

    always_comb
    begin
        m1_ctx     = m1_dly;
        m1_ctx.pvx = pvx;
        m1_ctx.pvy = pvy;
        m1_ctx.pxx = pxx;
        m1_ctx.pyy = pyy;
        m1_ctx.cc  = cc;
        m1_ctx.rc  = rc;
    end

    always_comb
    begin
        a1_next       = m1_ctx;
        a1_next.vn    = addq(m1_ctx.pvx, m1_ctx.pvy);
        a1_next.vmags = addq(m1_ctx.pxx, m1_ctx.pyy);
        a1_next.s2c   = addq(m1_ctx.c, m1_ctx.c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a1_next;
        end
    end

    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m2
        (.clk(clk), .en(en), .din(a1_reg), .dout(m2_dly));
    vlf_mul u_m2_m     (.clk(clk), .en(en), .a(a1_reg.rho), .b(a1_reg.vn),    .p(mm));
    vlf_mul u_m2_crho  (.clk(clk), .en(en), .a(a1_reg.cc),  .b(a1_reg.rho),   .p(crho));
    vlf_mul u_m2_vnvn  (.clk(clk), .en(en), .a(a1_reg.vn),  .b(a1_reg.vn),    .p(vnvn));
    vlf_mul u_m2_gvn   (.clk(clk), .en(en), .a(gm1),        .b(a1_reg.vn),    .p(gvn));
    vlf_mul u_m2_rhovm (.clk(clk), .en(en), .a(a1_reg.rho), .b(a1_reg.vmags), .p(rhovm));

    always_comb
    begin
        m2_ctx       = m2_dly;
        m2_ctx.m     = mm;
        m2_ctx.crho  = crho;
        m2_ctx.vnvn  = vnvn;
        m2_ctx.gvn   = gvn;
        m2_ctx.rhovm = rhovm;
    end

    always_comb
    begin
        a2_next      = m2_ctx;
        a2_next.a    = plus_side ? addq(m2_ctx.gvn, m2_ctx.s2c)
                                 : subq(m2_ctx.gvn, m2_ctx.s2c);
        a2_next.wnum = plus_side ? subq(m2_ctx.s2c, m2_ctx.vn)
                                 : -addq(m2_ctx.vn, m2_ctx.s2c);
        a2_next.hrv  = halfq(m2_ctx.rhovm);
        a2_next.hd   = halfq(subq(m2_ctx.vmags, m2_ctx.vnvn));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg <= a2_next;
        end
    end

    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m3
        (.clk(clk), .en(en), .din(a2_reg), .dout(m3_dly));
    vlf_mul u_m3_aa (.clk(clk), .en(en), .a(a2_reg.a), .b(a2_reg.a), .p(aa));

    always_comb
    begin
        m3_ctx    = m3_dly;
        m3_ctx.aa = aa;
    end

    always_comb
    begin
        a3_next     = m3_ctx;
        a3_next.haa = halfq(m3_ctx.aa);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg <= a3_next;
        end
    end

    // mach number, pressure, subsonic velocity term and energy quotient
    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(DIV_LAT)) u_dly_d1
        (.clk(clk), .en(en), .din(a3_reg), .dout(d1_dly));
    vlf_div u_d1_mach (.clk(clk), .en(en), .a(a3_reg.vn),   .b(a3_reg.c), .q(mach));
    vlf_div u_d1_p    (.clk(clk), .en(en), .a(a3_reg.crho), .b(g),        .q(pp));
    vlf_div u_d1_w    (.clk(clk), .en(en), .a(a3_reg.wnum), .b(g),        .q(ww));
    vlf_div u_d1_q2   (.clk(clk), .en(en), .a(a3_reg.haa),  .b(g2m1),     .q(q2));

    always_comb
    begin
        d1_ctx      = d1_dly;
        d1_ctx.mach = mach;
        d1_ctx.p    = pp;
        d1_ctx.w    = ww;
        d1_ctx.q2   = q2;
    end

    always_comb
    begin
        a4_next      = d1_ctx;
        a4_next.p    = (d1_ctx.p < q_t'(1)) ? q_t'(1) : d1_ctx.p;
        a4_next.mp   = plus_side ? addq(d1_ctx.mach, QONE) : subq(d1_ctx.mach, QONE);
        a4_next.e2   = addq(d1_ctx.hd, d1_ctx.q2);
        a4_next.full = plus_side ? (d1_ctx.mach >= QONE) : (d1_ctx.mach <= -QONE);
        a4_next.none = plus_side ? (d1_ctx.mach <= -QONE) : (d1_ctx.mach >= QONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg <= a4_next;
        end
    end

    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m4
        (.clk(clk), .en(en), .din(a4_reg), .dout(m4_dly));
    vlf_mul u_m4_mvx (.clk(clk), .en(en), .a(a4_reg.m),  .b(a4_reg.vx), .p(mvx));
    vlf_mul u_m4_pnx (.clk(clk), .en(en), .a(a4_reg.p),  .b(a4_reg.nx), .p(pnx));
    vlf_mul u_m4_mvy (.clk(clk), .en(en), .a(a4_reg.m),  .b(a4_reg.vy), .p(mvy));
    vlf_mul u_m4_pny (.clk(clk), .en(en), .a(a4_reg.p),  .b(a4_reg.ny), .p(pny));
    vlf_mul u_m4_t1  (.clk(clk), .en(en), .a(a4_reg.rc), .b(a4_reg.mp), .p(t1));
    vlf_mul u_m4_nxw (.clk(clk), .en(en), .a(a4_reg.nx), .b(a4_reg.w),  .p(nxw));
    vlf_mul u_m4_nyw (.clk(clk), .en(en), .a(a4_reg.ny), .b(a4_reg.w),  .p(nyw));

    always_comb
    begin
        m4_ctx     = m4_dly;
        m4_ctx.mvx = mvx;
        m4_ctx.pnx = pnx;
        m4_ctx.mvy = mvy;
        m4_ctx.pny = pny;
        m4_ctx.t1  = t1;
        m4_ctx.nxw = nxw;
        m4_ctx.nyw = nyw;
    end

    always_comb
    begin
        a5_next     = m4_ctx;
        a5_next.f1f = addq(m4_ctx.mvx, m4_ctx.pnx);
        a5_next.f2f = addq(m4_ctx.mvy, m4_ctx.pny);
        a5_next.ux  = addq(m4_ctx.vx, m4_ctx.nxw);
        a5_next.uy  = addq(m4_ctx.vy, m4_ctx.nyw);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a5_reg <= a5_next;
        end
    end

    // internal energy term of the supersonic flux
    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(DIV_LAT)) u_dly_d2
        (.clk(clk), .en(en), .din(a5_reg), .dout(d2_dly));
    vlf_div u_d2_dpg (.clk(clk), .en(en), .a(a5_reg.p), .b(gm1), .q(dpg));

    always_comb
    begin
        d2_ctx     = d2_dly;
        d2_ctx.dpg = dpg;
    end

    always_comb
    begin
        a6_next    = d2_ctx;
        a6_next.ef = addq(addq(d2_ctx.dpg, d2_ctx.hrv), d2_ctx.p);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a6_reg <= a6_next;
        end
    end

    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m5
        (.clk(clk), .en(en), .din(a6_reg), .dout(m5_dly));
    vlf_mul u_m5_ef3 (.clk(clk), .en(en), .a(a6_reg.vn), .b(a6_reg.ef), .p(ef3));
    vlf_mul u_m5_t2  (.clk(clk), .en(en), .a(a6_reg.t1), .b(a6_reg.mp), .p(t2));

    always_comb
    begin
        m5_ctx     = m5_dly;
        m5_ctx.ef3 = ef3;
        m5_ctx.t2  = t2;
    end

    always_comb
    begin
        a7_next    = m5_ctx;
        a7_next.f1 = plus_side ? quarterq(m5_ctx.t2) : -quarterq(m5_ctx.t2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a7_reg <= a7_next;
        end
    end

    vlf_dly #(.WIDTH($bits(ctx_t)), .DEPTH(MUL_LAT)) u_dly_m6
        (.clk(clk), .en(en), .din(a7_reg), .dout(m6_dly));
    vlf_mul u_m6_f1x (.clk(clk), .en(en), .a(a7_reg.f1), .b(a7_reg.ux), .p(f1x));
    vlf_mul u_m6_f1y (.clk(clk), .en(en), .a(a7_reg.f1), .b(a7_reg.uy), .p(f1y));
    vlf_mul u_m6_f13 (.clk(clk), .en(en), .a(a7_reg.f1), .b(a7_reg.e2), .p(f13));

    always_comb
    begin
        m6_ctx     = m6_dly;
        m6_ctx.f1x = f1x;
        m6_ctx.f1y = f1y;
        m6_ctx.f13 = f13;
    end

    // branch select
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (m6_ctx.full)
            begin
                f0_reg <= m6_ctx.m;
                f1_reg <= m6_ctx.f1f;
                f2_reg <= m6_ctx.f2f;
                f3_reg <= m6_ctx.ef3;
            end
            else if (m6_ctx.none)
            begin
                f0_reg <= '0;
                f1_reg <= '0;
                f2_reg <= '0;
                f3_reg <= '0;
            end
            else
            begin
                f0_reg <= m6_ctx.f1;
                f1_reg <= m6_ctx.f1x;
                f2_reg <= m6_ctx.f1y;
                f3_reg <= m6_ctx.f13;
            end
        end
    end

    assign f0 = f0_reg;
    assign f1 = f1_reg;
    assign f2 = f2_reg;
    assign f3 = f3_reg;
endmodule
`default_nettype wire

@@ rtl/core/van_leer_face_flux_top.sv @@
// top level of the van leer flux vector splitting face flux core
// throughput: one face per cycle; the whole pipeline advances together and holds on a stall
// the side pipeline depth is set by two 64-stage divider chains and six 4-stage multiplier rounds per side
// reset: asynchronous active-low rst_n clears valid bits and loads gamma_ratio with 91750
// a result held on the output stalls the whole pipeline, and the request side with it
`default_nettype none
module van_leer_face_flux_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // gamma_ratio write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [17:0]  cfg_data,
    // request side
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // normal_x, normal_y, left_density, left_vel_x, left_vel_y, left_sound_speed,
    // right_density, right_vel_x, right_vel_y, right_sound_speed
    input  wire logic [287:0] s_axis_tdata,
    // result side
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // mass_flux, xmom_flux, ymom_flux, energy_flux
    output logic [223:0]      m_axis_tdata
);
    import vlf_pkg::*;

    // configuration and the constants derived from it
    logic [GAM_W-1:0] gamma_reg;
    logic [GAM_W-1:0] g_reg;
    logic [GAM_W-1:0] gm1_reg;
    logic [G2_W-1:0]  g2m1_reg;
    logic [GAM_W-1:0] g_eff;
    logic [35:0]      g_sq;

    // pipeline control
    logic             en;
    logic             in_vld_reg;
    logic             vld_reg [0:SIDE_LAT-1];
    logic             out_vld_reg;

    // decoded request
    q_t nx_reg, ny_reg;
    q_t rl_reg, uxl_reg, uyl_reg, cl_reg;
    q_t rr_reg, uxr_reg, uyr_reg, cr_reg;

    // split fluxes and result
    q_t fp0, fp1, fp2, fp3;
    q_t fm0, fm1, fm2, fm3;
    logic [OUT_W-1:0] mass_reg, xmom_reg, ymom_reg, ener_reg;

    // gamma at or below one is treated as one lsb above one
    assign g_eff = (gamma_reg <= GAM_W'(65536)) ? GAM_W'(65537) : gamma_reg;
    assign g_sq  = 36'(g_eff) * 36'(g_eff);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAM_W'(G_RST);
            g_reg     <= GAM_W'(G_RST);
            gm1_reg   <= GAM_W'(GM1_RST);
            g2m1_reg  <= G2_W'(G2M1_RST);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gamma_reg <= cfg_data;
            g_reg    <= g_eff;
            gm1_reg  <= g_eff - GAM_W'(65536);
            g2m1_reg <= G2_W'((g_sq - 36'h1_0000_0000) >> 16);
        end
    end

    // everything moves when the output register is free or being drained
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    function automatic q_t snd(input logic [30:0] v);
        return (v == '0) ? q_t'(1) : q_t'({32'b0, v});
    endfunction

    // input register: widen each field, sound speed of zero becomes one lsb
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= q_t'(signed'(s_axis_tdata[17:0]));
            ny_reg  <= q_t'(signed'(s_axis_tdata[35:18]));
            rl_reg  <= q_t'({32'b0, s_axis_tdata[66:36]});
            uxl_reg <= q_t'(signed'(s_axis_tdata[98:67]));
            uyl_reg <= q_t'(signed'(s_axis_tdata[130:99]));
            cl_reg  <= snd(s_axis_tdata[161:131]);
            rr_reg  <= q_t'({32'b0, s_axis_tdata[192:162]});
            uxr_reg <= q_t'(signed'(s_axis_tdata[224:193]));
            uyr_reg <= q_t'(signed'(s_axis_tdata[256:225]));
            cr_reg  <= snd(s_axis_tdata[287:257]);
        end
    end

    // valid bits ride next to the side pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < SIDE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            in_vld_reg <= s_axis_tvalid;
            vld_reg[0] <= in_vld_reg;
            for (int k = 1; k < SIDE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[SIDE_LAT-1];
        end
    end

    // plus part from the left state
    vlf_side u_plus (
        .clk(clk), .en(en), .plus_side(1'b1),
        .nx(nx_reg), .ny(ny_reg), .rho(rl_reg), .vx(uxl_reg), .vy(uyl_reg), .c(cl_reg),
        .g(q_t'({45'b0, g_reg})), .gm1(q_t'({45'b0, gm1_reg})),
        .g2m1(q_t'({43'b0, g2m1_reg})),
        .f0(fp0), .f1(fp1), .f2(fp2), .f3(fp3)
    );

    // minus part from the right state
    vlf_side u_minus (
        .clk(clk), .en(en), .plus_side(1'b0),
        .nx(nx_reg), .ny(ny_reg), .rho(rr_reg), .vx(uxr_reg), .vy(uyr_reg), .c(cr_reg),
        .g(q_t'({45'b0, g_reg})), .gm1(q_t'({45'b0, gm1_reg})),
        .g2m1(q_t'({43'b0, g2m1_reg})),
        .f0(fm0), .f1(fm1), .f2(fm2), .f3(fm3)
    );

    // sum of the two parts clipped to the q40.16 output range
    function automatic logic [OUT_W-1:0] outsat(input q_t a, input q_t b);
        q_t s;
        s = addq(a, b);
        if (s > OUT_MAX)
            s = OUT_MAX;
        else if (s < OUT_MIN)
            s = OUT_MIN;
        return s[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mass_reg <= outsat(fp0, fm0);
            xmom_reg <= outsat(fp1, fm1);
            ymom_reg <= outsat(fp2, fm2);
            ener_reg <= outsat(fp3, fm3);
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {ener_reg, ymom_reg, xmom_reg, mass_reg};

    // derived gamma terms stay positive, so no divide by zero reaches the dividers
    a_gm1_pos: assert property (@(posedge clk) disable iff (!rst_n)
        gm1_reg != '0)
        else $error("gamma minus one is zero");

    a_g2m1_pos: assert property (@(posedge clk) disable iff (!rst_n)
        g2m1_reg != '0)
        else $error("gamma squared minus one is zero");

    // a held result must freeze the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> $stable(vld_reg[SIDE_LAT-1]) && $stable(in_vld_reg))
        else $error("pipeline moved while the result was stalled");
endmodule
`default_nettype wire
